### rtl/core/mkar_pkg.sv
// Shared types and constants for the multi-key auto-repeat engine.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package mkar_pkg;

    // Payload field widths.
    localparam int REQ_W = 2;
    localparam int KEY_W = 8;
    localparam int CMD_W = 16;
    localparam int CNT_W = 16;

    // Request codes carried by req_type.
    localparam logic [REQ_W-1:0] REQ_PRESS   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd3;

    // Result status codes.
    localparam logic STATUS_ACT  = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    // Most results that one tick may give.
    localparam int RESULT_CAP = 8;
    localparam int CAP_W      = $clog2(RESULT_CAP + 1);

    // Default number of key slots.
    localparam int DEFAULT_SLOTS = 8;

    // Configuration port layout: one 32-bit register every four bytes.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_INIT_DELAY = 1'b0;
    localparam logic REG_REPEAT     = 1'b1;
    localparam logic [CNT_W-1:0] INIT_DELAY_RST = 16'd500;
    localparam logic [CNT_W-1:0] REPEAT_RST     = 16'd33;

    // Control strobes from the sequencer to the slot memories.
    typedef struct packed {
        logic rd_en;
        logic wr_slot_en;
        logic wr_cnt_en;
    } ram_ctrl_t;

endpackage

### rtl/core/mkar_cfg_regs.sv
// Configuration registers (initial delay and repeat interval) behind an APB-style port.
// Depends on mkar_pkg.
`timescale 1ns / 1ps

module mkar_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mkar_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mkar_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mkar_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [mkar_pkg::CNT_W-1:0]      initial_delay,
    output logic [mkar_pkg::CNT_W-1:0]      repeat_interval
);
    import mkar_pkg::*;

    logic [CNT_W-1:0] init_delay_reg;
    logic [CNT_W-1:0] repeat_reg;
    logic             reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // The register is written in the access phase of a write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_delay_reg <= INIT_DELAY_RST;
            repeat_reg     <= REPEAT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_INIT_DELAY: init_delay_reg <= pwdata[CNT_W-1:0];
                REG_REPEAT:     repeat_reg     <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (reg_idx)
            REG_INIT_DELAY: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, init_delay_reg};
            REG_REPEAT:     prdata = {{(APB_DATA_W-CNT_W){1'b0}}, repeat_reg};
            default:        prdata = '0;
        endcase
    end

    assign initial_delay   = init_delay_reg;
    assign repeat_interval = repeat_reg;

endmodule

### rtl/core/mkar_slot_ram.sv
// Per-slot storage of key, command and countdown, with registered reads.
// Depends on mkar_pkg.
`timescale 1ns / 1ps

module mkar_slot_ram #(
    parameter int SLOTS = mkar_pkg::DEFAULT_SLOTS
) (
    input  logic                                    aclk,
    input  mkar_pkg::ram_ctrl_t                     ctrl,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
    input  logic [mkar_pkg::KEY_W-1:0]              wr_key,
    input  logic [mkar_pkg::CMD_W-1:0]              wr_cmd,
    input  logic [mkar_pkg::CNT_W-1:0]              wr_cnt,
    output logic [mkar_pkg::KEY_W-1:0]              rd_key,
    output logic [mkar_pkg::CMD_W-1:0]              rd_cmd,
    output logic [mkar_pkg::CNT_W-1:0]              rd_cnt
);
    import mkar_pkg::*;

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [CMD_W-1:0] cmd_mem [SLOTS];
    logic [CNT_W-1:0] cnt_mem [SLOTS];

    logic [KEY_W-1:0] rd_key_reg;
    logic [CMD_W-1:0] rd_cmd_reg;
    logic [CNT_W-1:0] rd_cnt_reg;

    // Key and command are written together when a slot is taken.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_slot_en) begin
            key_mem[wr_addr] <= wr_key;
            cmd_mem[wr_addr] <= wr_cmd;
        end
    end

    // The countdown is written on a press and on every tick update.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_cnt_en) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_cmd_reg <= cmd_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;
    assign rd_cmd = rd_cmd_reg;
    assign rd_cnt = rd_cnt_reg;

endmodule

### rtl/core/mkar_seq.sv
// Slot-scan sequencer: one slot per cycle unless a firing slot waits, via a shared key compare
// and countdown decrement; drives the result register. Depends on mkar_pkg, mkar_slot_ram.
`timescale 1ns / 1ps

module mkar_seq #(
    parameter int SLOTS = mkar_pkg::DEFAULT_SLOTS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [mkar_pkg::CNT_W-1:0]   initial_delay,
    input  logic [mkar_pkg::CNT_W-1:0]   repeat_interval,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mkar_pkg::REQ_W-1:0]   s_req_type,
    input  logic [mkar_pkg::KEY_W-1:0]   s_key_id,
    input  logic [mkar_pkg::CMD_W-1:0]   s_command_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mkar_pkg::CMD_W-1:0]   m_cmd_out,
    output logic                         m_status,
    output logic                         m_last
);
    import mkar_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W = $clog2(SLOTS + 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(SLOTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Control state.
    logic [1:0]       state_reg;
    logic [SLOTS-1:0] valid_reg;
    logic             p_vld_reg;
    logic             pend_vld_reg;
    logic             m_valid_reg;

    // Item and scan bookkeeping.
    logic [REQ_W-1:0] req_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [PTR_W-1:0] addr_reg;
    logic [IDX_W-1:0] p_idx_reg;
    logic             match_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [CAP_W-1:0] fire_cnt_reg;
    logic [CMD_W-1:0] pend_cmd_reg;
    logic [CMD_W-1:0] m_cmd_reg;
    logic             m_status_reg;
    logic             m_last_reg;

    // Slot memory interface.
    ram_ctrl_t        ram_ctrl;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_cnt;
    logic [KEY_W-1:0] rd_key;
    logic [CMD_W-1:0] rd_cmd;
    logic [CNT_W-1:0] rd_cnt;

    // Shared datapath and sequencing signals.
    logic             out_free;
    logic             slot_live;
    logic             key_hit;
    logic             cnt_armed;
    logic [CNT_W-1:0] cnt_dec;
    logic             is_press;
    logic             is_tick;
    logic             fire;
    logic             adv;
    logic             more;
    logic             fin_done;
    logic             push_en;
    logic [CMD_W-1:0] push_cmd;
    logic             push_status;
    logic             push_last;
    logic [CNT_W-1:0] press_cnt;

    mkar_slot_ram #(
        .SLOTS (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .ctrl    (ram_ctrl),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .wr_addr (wr_addr),
        .wr_key  (key_reg),
        .wr_cmd  (cmd_reg),
        .wr_cnt  (wr_cnt),
        .rd_key  (rd_key),
        .rd_cmd  (rd_cmd),
        .rd_cnt  (rd_cnt)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign is_press = (req_reg == REQ_PRESS);
    assign is_tick  = (req_reg == REQ_TICK);
    assign more     = (addr_reg < PTR_END);

    // Shared compare and decrement unit, applied to the slot last read from the slot memory.
    assign slot_live = p_vld_reg && valid_reg[p_idx_reg];
    assign key_hit   = slot_live && (rd_key == key_reg);
    assign cnt_armed = slot_live && (rd_cnt != '0);
    assign cnt_dec   = rd_cnt - CNT_W'(1);
    assign fire      = is_tick && cnt_armed && (cnt_dec == '0)
                       && (fire_cnt_reg < CAP_W'(RESULT_CAP));

    // A firing slot waits only when the previous firing cannot leave yet.
    assign adv = !(fire && pend_vld_reg && !out_free);

    // Countdown loaded on a press; a zero delay counts as one tick, a zero interval loads zero.
    assign press_cnt = (repeat_interval == '0) ? '0 :
                       ((initial_delay == '0) ? CNT_W'(1) : initial_delay);

    assign wr_addr = (state_reg == ST_FINISH) ? free_idx_reg : p_idx_reg;

    // Memory strobes, countdown data and result pushes for each state.
    always_comb begin
        ram_ctrl    = '0;
        wr_cnt      = cnt_dec;
        push_en     = 1'b0;
        push_cmd    = pend_cmd_reg;
        push_status = STATUS_ACT;
        push_last   = 1'b0;
        fin_done    = 1'b0;
        unique case (state_reg)
            ST_SCAN: begin
                ram_ctrl.rd_en = adv && more;
                if (adv && is_tick && cnt_armed && ((cnt_dec != '0) || fire)) begin
                    ram_ctrl.wr_cnt_en = 1'b1;
                    wr_cnt = fire ? repeat_interval : cnt_dec;
                end
                if (fire && pend_vld_reg && out_free) begin
                    push_en = 1'b1;
                end
            end
            ST_FINISH: begin
                if (is_press && !match_reg) begin
                    fin_done = out_free;
                    if (out_free) begin
                        push_en            = 1'b1;
                        push_cmd           = cmd_reg;
                        push_last          = 1'b1;
                        push_status        = free_found_reg ? STATUS_ACT : STATUS_DROP;
                        ram_ctrl.wr_slot_en = free_found_reg;
                        ram_ctrl.wr_cnt_en  = free_found_reg;
                        wr_cnt             = press_cnt;
                    end
                end else if (is_tick && pend_vld_reg) begin
                    fin_done = out_free;
                    if (out_free) begin
                        push_en   = 1'b1;
                        push_last = 1'b1;
                    end
                end else begin
                    fin_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Sequencer control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            p_vld_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_req_type == REQ_CLEAR) begin
                            valid_reg <= '0;
                        end else begin
                            state_reg    <= ST_SCAN;
                            p_vld_reg    <= 1'b0;
                            pend_vld_reg <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (adv) begin
                        p_vld_reg <= more;
                        if (!more) begin
                            state_reg <= ST_FINISH;
                        end
                        if (key_hit && (req_reg == REQ_RELEASE)) begin
                            valid_reg[p_idx_reg] <= 1'b0;
                        end
                        if (fire) begin
                            pend_vld_reg <= 1'b1;
                        end
                    end
                end
                ST_FINISH: begin
                    if (fin_done) begin
                        state_reg <= ST_IDLE;
                        if (is_press && !match_reg && free_found_reg) begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Item capture and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            req_reg        <= s_req_type;
            key_reg        <= s_key_id;
            cmd_reg        <= s_command_id;
            addr_reg       <= '0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            fire_cnt_reg   <= '0;
        end else if ((state_reg == ST_SCAN) && adv) begin
            p_idx_reg <= addr_reg[IDX_W-1:0];
            if (more) begin
                addr_reg <= addr_reg + PTR_W'(1);
            end
            if (key_hit && is_press) begin
                match_reg <= 1'b1;
            end
            if (is_press && p_vld_reg && !valid_reg[p_idx_reg] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= p_idx_reg;
            end
            if (fire) begin
                pend_cmd_reg <= rd_cmd;
                fire_cnt_reg <= fire_cnt_reg + CAP_W'(1);
            end
        end
    end

    // Result register: one beat waits here while the scan goes on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            m_cmd_reg    <= push_cmd;
            m_status_reg <= push_status;
            m_last_reg   <= push_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_cmd_out = m_cmd_reg;
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

endmodule

### rtl/core/multi_key_auto_repeat.sv
// Top level of the multi-key auto-repeat engine: configuration port and slot sequencer.
// Depends on mkar_pkg, mkar_cfg_regs, mkar_seq (and through it mkar_slot_ram).
`timescale 1ns / 1ps

// Auto-repeat engine for up to SLOTS keys held at once. A press of a key not yet held
// takes the lowest free slot and gives one activation beat; a press with every slot in
// use gives one beat with status set. Each tick counts down the armed slots and gives a
// beat for each slot that expires, at most eight per tick (a slot that would expire past
// that cap keeps its count), the final beat of an item carrying last. Release and clear
// give no beat. A clear completes in the cycle it is accepted. A press, release or tick
// starts a slot scan, in which the slot memory is read one slot per cycle through a
// registered read port, unless a firing slot must wait for an earlier result beat to be
// taken, and each slot passes through a single key comparator and countdown decrementer;
// a closing state follows the scan. The block accepts no new item until the current one
// has finished. Configuration registers: initial delay at byte address 0, repeat interval
// at byte address 4.
module multi_key_auto_repeat #(
    parameter int SLOTS = mkar_pkg::DEFAULT_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mkar_pkg::REQ_W-1:0]      s_req_type,
    input  logic [mkar_pkg::KEY_W-1:0]      s_key_id,
    input  logic [mkar_pkg::CMD_W-1:0]      s_command_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mkar_pkg::CMD_W-1:0]      m_cmd_out,
    output logic                            m_status,
    output logic                            m_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mkar_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mkar_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mkar_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mkar_pkg::*;

    logic [CNT_W-1:0] initial_delay;
    logic [CNT_W-1:0] repeat_interval;

    mkar_cfg_regs u_cfg_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .initial_delay   (initial_delay),
        .repeat_interval (repeat_interval)
    );

    mkar_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .initial_delay   (initial_delay),
        .repeat_interval (repeat_interval),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_key_id        (s_key_id),
        .s_command_id    (s_command_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cmd_out       (m_cmd_out),
        .m_status        (m_status),
        .m_last          (m_last)
    );

    // A dropped press is always the only, and so the final, beat of its item.
    a_drop_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_DROP) |-> m_last)
        else $error("dropped-press beat without last");

    // A clear completes in the cycle it is accepted.
    a_clear_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_CLEAR) |=> s_ready)
        else $error("not ready after a clear");

    // Every other request starts a slot scan, during which no item is taken.
    a_scan_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type != REQ_CLEAR) |=> !s_ready)
        else $error("ready during a slot scan");

endmodule
